### rtl/pfc_pkg.sv
// Shared types and constants for the Playfair text cipher core.
`timescale 1ns / 1ps

package pfc_pkg;

   localparam int SQUARE_SIDE = 5;
   localparam int LETTER_W    = 5;
   localparam int IDX_W       = 3;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int ROW_W       = SQUARE_SIDE * LETTER_W;

   localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
   localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
   localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
   localparam logic [LETTER_W-1:0] LETTER_MAX = 5'd25;

   localparam logic [6:0] ASCII_LOWER_A = 7'd97;
   localparam logic [6:0] ASCII_LOWER_Z = 7'd122;

   // Register indexes, one 32-bit word apart.
   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_ROW0 = 3'd1;
   localparam logic [2:0] REG_ROW1 = 3'd2;
   localparam logic [2:0] REG_ROW2 = 3'd3;
   localparam logic [2:0] REG_ROW3 = 3'd4;
   localparam logic [2:0] REG_ROW4 = 3'd5;

   typedef logic [SQUARE_SIDE-1:0][LETTER_W-1:0] row_type;
   typedef row_type [SQUARE_SIDE-1:0] square_type;

   typedef struct packed {
      logic       mode_decrypt;
      square_type square;
   } cfg_type;

   // One letter pair handed from the front end to the cipher engine.
   typedef struct packed {
      logic [LETTER_W-1:0] first;
      logic [LETTER_W-1:0] second;
      logic                fin;
      logic                text_end;
   } pair_type;

endpackage

### rtl/pfc_csr.sv
// Configuration register file: mode and the five rows of the key square.
`timescale 1ns / 1ps

module pfc_csr
   import pfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MODE: cfg_in.mode_decrypt = csr_pwdata[0];
            REG_ROW0: cfg_in.square[0]    = csr_pwdata[ROW_W-1:0];
            REG_ROW1: cfg_in.square[1]    = csr_pwdata[ROW_W-1:0];
            REG_ROW2: cfg_in.square[2]    = csr_pwdata[ROW_W-1:0];
            REG_ROW3: cfg_in.square[3]    = csr_pwdata[ROW_W-1:0];
            REG_ROW4: cfg_in.square[4]    = csr_pwdata[ROW_W-1:0];
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MODE: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.mode_decrypt};
         REG_ROW0: csr_prdata = {{(CSR_DATA_W-ROW_W){1'b0}}, cfg_ff.square[0]};
         REG_ROW1: csr_prdata = {{(CSR_DATA_W-ROW_W){1'b0}}, cfg_ff.square[1]};
         REG_ROW2: csr_prdata = {{(CSR_DATA_W-ROW_W){1'b0}}, cfg_ff.square[2]};
         REG_ROW3: csr_prdata = {{(CSR_DATA_W-ROW_W){1'b0}}, cfg_ff.square[3]};
         REG_ROW4: csr_prdata = {{(CSR_DATA_W-ROW_W){1'b0}}, cfg_ff.square[4]};
         default:  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/pfc_front.sv
// Front end: filters and folds text bytes and forms letter pairs.
`timescale 1ns / 1ps

module pfc_front
   import pfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       mode_decrypt,
   input  logic       q_full,
   output logic       push_valid,
   output pair_type   push_data
);

   logic                pend_valid_ff, pend_valid_in;
   logic [LETTER_W-1:0] pend_letter_ff, pend_letter_in;
   logic                hold_valid_ff, hold_valid_in;
   pair_type            hold_ff, hold_in;

   logic                is_upper, is_lower, is_letter;
   logic [7:0]          raw;
   logic [LETTER_W-1:0] letter;
   logic                p0_v, p1_v;
   pair_type            p0, p1;
   logic                accept;

   assign req_tready = !hold_valid_ff && !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      is_upper  = req_tdata inside {[8'h41:8'h5A]};
      is_lower  = req_tdata inside {[8'h61:8'h7A]};
      is_letter = is_upper || is_lower;
      raw       = is_upper ? (req_tdata - 8'h41) : (req_tdata - 8'h61);
      letter    = raw[LETTER_W-1:0];
      if (letter == LETTER_J) begin
         letter = LETTER_I;
      end

      p0_v           = 1'b0;
      p1_v           = 1'b0;
      p0             = '0;
      p1             = '0;
      pend_valid_in  = pend_valid_ff;
      pend_letter_in = pend_letter_ff;

      if (is_letter) begin
         if (pend_valid_ff) begin
            p0_v     = 1'b1;
            p0.first = pend_letter_ff;
            // In encrypt mode a doubled pair is split with x; the second letter waits on.
            if (!mode_decrypt && (pend_letter_ff == letter)) begin
               p0.second = LETTER_X;
            end else begin
               p0.second      = letter;
               pend_valid_in  = 1'b0;
               pend_letter_in = '0;
            end
         end else begin
            pend_valid_in  = 1'b1;
            pend_letter_in = letter;
         end
      end

      if (req_tlast) begin
         if (pend_valid_in) begin
            if (p0_v) begin
               p1_v      = 1'b1;
               p1.first  = pend_letter_in;
               p1.second = LETTER_X;
            end else begin
               p0_v      = 1'b1;
               p0.first  = pend_letter_in;
               p0.second = LETTER_X;
            end
         end
         pend_valid_in  = 1'b0;
         pend_letter_in = '0;
      end

      p0.fin      = !p1_v;
      p1.fin      = 1'b1;
      p0.text_end = req_tlast;
      p1.text_end = req_tlast;
   end

   assign push_valid = hold_valid_ff || (accept && p0_v);
   assign push_data  = hold_valid_ff ? hold_ff : p0;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (hold_valid_ff && !q_full) begin
         hold_valid_in = 1'b0;
      end
      if (accept && p1_v) begin
         hold_valid_in = 1'b1;
         hold_in       = p1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff  <= 1'b0;
         pend_letter_ff <= '0;
         hold_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            pend_valid_ff  <= pend_valid_in;
            pend_letter_ff <= pend_letter_in;
         end
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

   a_hold_blocks_input: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> !req_tready)
      else $error("input taken while a second pair is held");

   a_burst_is_held: assert property (@(posedge clock) disable iff (reset)
      (accept && p1_v) |=> hold_valid_ff)
      else $error("second pair of a burst was not held");

   a_hold_waits_on_full: assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && q_full) |=> (hold_valid_ff && $stable(hold_ff)))
      else $error("held pair dropped while the queue was full");

endmodule

### rtl/pfc_queue.sv
// Small pair queue between the front end and the cipher engine.
`timescale 1ns / 1ps

module pfc_queue
   import pfc_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  pair_type push_data,
   output logic     full,
   output logic     pop_valid,
   input  logic     pop_ready,
   output pair_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pair_type         mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

   a_pop_counts: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count missed a pop");

endmodule

### rtl/pfc_back.sv
// Cipher engine: locates both letters of a pair, applies the square rules
// and delivers the two result letters one item per cycle while rsp_tready is high.
`timescale 1ns / 1ps

module pfc_back
   import pfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  pair_type   pop_data,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   output logic [0:0] rsp_tuser
);

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } loc_type;

   // First matching cell in row-major order; row 0, column 0 when absent.
   function automatic loc_type locate(square_type sq, logic [LETTER_W-1:0] l);
      loc_type res;
      res = '0;
      for (int r = SQUARE_SIDE - 1; r >= 0; r--) begin
         for (int c = SQUARE_SIDE - 1; c >= 0; c--) begin
            if (sq[r][c] == l) begin
               res.row = IDX_W'(r);
               res.col = IDX_W'(c);
            end
         end
      end
      return res;
   endfunction

   function automatic logic [IDX_W-1:0] wrap_step(logic [IDX_W-1:0] v, logic dec);
      logic [IDX_W-1:0] res;
      if (dec) begin
         res = (v == '0) ? IDX_W'(SQUARE_SIDE - 1) : v - 1'b1;
      end else begin
         res = (v == IDX_W'(SQUARE_SIDE - 1)) ? '0 : v + 1'b1;
      end
      return res;
   endfunction

   function automatic logic [6:0] to_ascii(logic [LETTER_W-1:0] v);
      return (v > LETTER_MAX) ? ASCII_LOWER_Z : ASCII_LOWER_A + 7'(v);
   endfunction

   logic       loc_valid_ff;
   loc_type    loc_a_ff, loc_b_ff;
   logic       loc_fin_ff, loc_end_ff;

   logic       out_valid_ff, out_valid_in;
   logic       out_phase_ff, out_phase_in;
   logic [6:0] out_x_ff, out_y_ff;
   logic       out_fin_ff, out_end_ff;

   logic       out_take, out_load, loc_advance;
   loc_type    cur_a, cur_b;
   logic [IDX_W-1:0] ra, ca, rb, cb;
   logic [LETTER_W-1:0] cell_x, cell_y;

   assign out_take    = out_valid_ff && rsp_tready;
   assign out_load    = !out_valid_ff || (out_take && out_phase_ff);
   assign loc_advance = loc_valid_ff && out_load;
   assign pop_ready   = !loc_valid_ff || out_load;

   assign cur_a = locate(cfg.square, pop_data.first);
   assign cur_b = locate(cfg.square, pop_data.second);

   always_comb begin
      ra = loc_a_ff.row;
      ca = loc_a_ff.col;
      rb = loc_b_ff.row;
      cb = loc_b_ff.col;
      if (loc_a_ff.row == loc_b_ff.row) begin
         cell_x = cfg.square[ra][wrap_step(ca, cfg.mode_decrypt)];
         cell_y = cfg.square[rb][wrap_step(cb, cfg.mode_decrypt)];
      end else if (loc_a_ff.col == loc_b_ff.col) begin
         cell_x = cfg.square[wrap_step(ra, cfg.mode_decrypt)][ca];
         cell_y = cfg.square[wrap_step(rb, cfg.mode_decrypt)][cb];
      end else begin
         cell_x = cfg.square[ra][cb];
         cell_y = cfg.square[rb][ca];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_phase_in = out_phase_ff;
      if (out_take) begin
         if (!out_phase_ff) begin
            out_phase_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
            out_phase_in = 1'b0;
         end
      end
      if (loc_advance) begin
         out_valid_in = 1'b1;
         out_phase_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loc_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         out_phase_ff <= 1'b0;
      end else begin
         if (pop_ready) begin
            loc_valid_ff <= pop_valid;
         end
         out_valid_ff <= out_valid_in;
         out_phase_ff <= out_phase_in;
      end
      if (pop_ready && pop_valid) begin
         loc_a_ff   <= cur_a;
         loc_b_ff   <= cur_b;
         loc_fin_ff <= pop_data.fin;
         loc_end_ff <= pop_data.text_end;
      end
      if (loc_advance) begin
         out_x_ff   <= to_ascii(cell_x);
         out_y_ff   <= to_ascii(cell_y);
         out_fin_ff <= loc_fin_ff;
         out_end_ff <= loc_end_ff;
      end
   end

   assign rsp_tvalid  = out_valid_ff;
   assign rsp_tdata   = {1'b0, (out_phase_ff ? out_y_ff : out_x_ff)};
   assign rsp_tlast   = out_phase_ff && out_fin_ff;
   assign rsp_tuser   = out_phase_ff && out_fin_ff && out_end_ff;

   a_phase_needs_valid: assert property (@(posedge clock) disable iff (reset)
      out_phase_ff |-> out_valid_ff)
      else $error("second letter phase without a pair");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (out_take && !out_phase_ff) |=> (out_valid_ff && out_phase_ff))
      else $error("second letter of a pair was skipped");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >= 8'd97 && rsp_tdata <= 8'd122))
      else $error("result letter outside a to z");

   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast)
      else $error("text end without run end");

endmodule

### rtl/playfair_text_cipher_core.sv
// Top level of the Playfair text cipher core.
//
//  channel  direction  fields
//  req      in         tdata[7:0] text_byte, tlast text_last
//  rsp      out        tdata[6:0] out_letter, tlast run_last, tuser[0] text_end
//  csr      in/out     APB registers: mode_decrypt, square_row0..square_row4
//
// The front end takes one byte per cycle while the pair queue has room; a
// byte that yields two pairs holds off the input until its second pair is pushed.
// The cipher engine delivers one letter per cycle while rsp is ready; the
// first letter of a pair passes the queue, the locate register and the output
// register before it is offered.
// Reset is synchronous; flags, pointers and settings clear at once, no clearing pass; pair data is not reset.
// The output register lets the queue keep filling while rsp is stalled.
`timescale 1ns / 1ps

module playfair_text_cipher_core
   import pfc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] text_byte
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [6:0] out_letter, [7] zero
   output logic                  rsp_tlast,
   output logic [0:0]            rsp_tuser,   // [0] text_end
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type  cfg;
   logic     q_full;
   logic     push_valid;
   pair_type push_data;
   logic     pop_valid;
   logic     pop_ready;
   pair_type pop_data;

   pfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pfc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .mode_decrypt (cfg.mode_decrypt),
      .q_full       (q_full),
      .push_valid   (push_valid),
      .push_data    (push_data)
   );

   pfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   pfc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### tb/tb_top.sv
// Self-checking regression bench for the Playfair text cipher core.
`timescale 1ns / 1ps

module tb_top
   import pfc_pkg::*;
();

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 11;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 62;
   localparam int DRAIN_CYCLES = 12;
   localparam int LONG_HOLD    = 400;
   localparam int QUIET_LIMIT  = 2000;
   localparam int MAX_REPORTS  = 40;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   // Kinds of key square loaded between phases.
   localparam int SQ_ALPHA   = 0;
   localparam int SQ_SHUFFLE = 1;
   localparam int SQ_ZERO    = 2;
   localparam int SQ_ONES    = 3;
   localparam int SQ_NOISE   = 4;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       text_last;
   } text_item;

   typedef struct packed {
      logic [6:0] letter;
      logic       run_last;
      logic       text_end;
   } letter_result;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'd0;    // [7:0] text_byte
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;           // [6:0] out_letter, [7] zero
   logic                  rsp_tlast;
   logic [0:0]            rsp_tuser;           // [0] text_end
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Mirror of the programmed settings and of the letter waiting for a partner.
   logic                decrypt_mode = 1'b0;
   logic [ROW_W-1:0]    square_rows [SQUARE_SIDE] = '{default: '0};
   logic                held_valid = 1'b0;
   logic [LETTER_W-1:0] held_letter = '0;

   text_item     text_queue [$];
   letter_result step_letters [$];
   letter_result letter_expect [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int error_count = 0;
   int items_accepted = 0;
   int letters_checked = 0;
   int texts_closed = 0;
   int bursts_seen = 0;
   logic [7:0] prev_byte = CHAR_LOWER_A;

   playfair_text_cipher_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic logic [LETTER_W-1:0] square_at(input int row, input int col);
      return square_rows[row][LETTER_W*col +: LETTER_W];
   endfunction

   // Scanning backward leaves the first match in row-major order; no match
   // leaves row 0, column 0.
   task automatic find_letter(input logic [LETTER_W-1:0] letter, output int row,
                              output int col);
      row = 0;
      col = 0;
      for (int r = SQUARE_SIDE - 1; r >= 0; r--) begin
         for (int c = SQUARE_SIDE - 1; c >= 0; c--) begin
            if (square_at(r, c) == letter) begin
               row = r;
               col = c;
            end
         end
      end
   endtask

   function automatic logic [6:0] letter_ascii(input logic [LETTER_W-1:0] code);
      return (code > LETTER_MAX) ? ASCII_LOWER_Z : ASCII_LOWER_A + 7'(code);
   endfunction

   task automatic cipher_pair(input logic [LETTER_W-1:0] first,
                              input logic [LETTER_W-1:0] second);
      int r1, c1, r2, c2, shift;
      logic [LETTER_W-1:0] out1, out2;
      shift = decrypt_mode ? SQUARE_SIDE - 1 : 1;
      find_letter(first, r1, c1);
      find_letter(second, r2, c2);
      if (r1 == r2) begin
         out1 = square_at(r1, (c1 + shift) % SQUARE_SIDE);
         out2 = square_at(r2, (c2 + shift) % SQUARE_SIDE);
      end else if (c1 == c2) begin
         out1 = square_at((r1 + shift) % SQUARE_SIDE, c1);
         out2 = square_at((r2 + shift) % SQUARE_SIDE, c2);
      end else begin
         out1 = square_at(r1, c2);
         out2 = square_at(r2, c1);
      end
      step_letters.push_back('{letter: letter_ascii(out1), run_last: 1'b0, text_end: 1'b0});
      step_letters.push_back('{letter: letter_ascii(out2), run_last: 1'b0, text_end: 1'b0});
   endtask

   // Works out the letters that one accepted text byte must produce.
   task automatic cipher_text_byte(input logic [7:0] ch, input logic fin);
      logic                is_alpha;
      logic [LETTER_W-1:0] code;
      int                  tail;
      step_letters.delete();
      is_alpha = 1'b0;
      code = '0;
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
         is_alpha = 1'b1;
         code = LETTER_W'(ch - CHAR_UPPER_A);
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
         is_alpha = 1'b1;
         code = LETTER_W'(ch - CHAR_LOWER_A);
      end
      if (code == LETTER_J) begin
         code = LETTER_I;
      end
      if (is_alpha) begin
         if (!held_valid) begin
            held_valid = 1'b1;
            held_letter = code;
         end else if (!decrypt_mode && held_letter == code) begin
            // A doubled pair is split by x; the repeated letter stays held.
            cipher_pair(held_letter, LETTER_X);
         end else begin
            cipher_pair(held_letter, code);
            held_valid = 1'b0;
            held_letter = '0;
         end
      end
      if (fin) begin
         if (held_valid) begin
            cipher_pair(held_letter, LETTER_X);
         end
         held_valid = 1'b0;
         held_letter = '0;
      end
      if (step_letters.size() != 0) begin
         tail = step_letters.size() - 1;
         step_letters[tail].run_last = 1'b1;
         step_letters[tail].text_end = fin;
         if (step_letters.size() == 4) begin
            bursts_seen++;
         end
         foreach (step_letters[k]) begin
            letter_expect.push_back(step_letters[k]);
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endtask

   // Sender: offers queued bytes, with random gaps.
   always @(posedge clock) begin
      text_item offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'd0;
         req_tlast <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            items_accepted++;
            cipher_text_byte(req_tdata, req_tlast);
         end
         if (!req_tvalid || req_tready) begin
            if (text_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offer = text_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= offer.text_byte;
               req_tlast <= offer.text_last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver readiness, including the long hold-off that backs the core up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      letter_result want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (letter_expect.size() == 0) begin
            report_mismatch("unexpected letter", 32'd0,
                            32'({rsp_tuser, rsp_tlast, rsp_tdata}));
         end else begin
            want = letter_expect.pop_front();
            letters_checked++;
            if (want.text_end) begin
               texts_closed++;
            end
            if (rsp_tdata !== {1'b0, want.letter}) begin
               report_mismatch("out_letter", 32'({1'b0, want.letter}), 32'(rsp_tdata));
            end
            if (rsp_tlast !== want.run_last) begin
               report_mismatch("run_last", 32'(want.run_last), 32'(rsp_tlast));
            end
            if (rsp_tuser[0] !== want.text_end) begin
               report_mismatch("text_end", 32'(want.text_end), 32'(rsp_tuser[0]));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t ns: no item moved for %0d cycles, %0d letters outstanding",
                  $time, QUIET_LIMIT, letter_expect.size());
         $display("playfair_text_cipher_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_cycle(input logic wr, input logic [IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] wdata,
                            output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Writes a register, reads it back and updates the mirror.
   task automatic set_register(input logic [IDX_W-1:0] index,
                               input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] kept, readback;
      kept = (index == REG_MODE) ? (value & 32'h1) : (value & 32'h01FF_FFFF);
      csr_cycle(1'b1, index, value, readback);
      csr_cycle(1'b0, index, '0, readback);
      if (readback !== kept) begin
         report_mismatch("register readback", kept, readback);
      end
      if (index == REG_MODE) begin
         decrypt_mode = kept[0];
      end else begin
         square_rows[index - REG_ROW0] = kept[ROW_W-1:0];
      end
   endtask

   task automatic load_config(input logic mode, input int kind);
      logic [LETTER_W-1:0]   cells [SQUARE_SIDE*SQUARE_SIDE];
      logic [LETTER_W-1:0]   swap;
      logic [CSR_DATA_W-1:0] word;
      int                    k, pick;
      k = 0;
      for (int v = 0; v <= LETTER_MAX; v++) begin
         if (v != LETTER_J) begin
            cells[k] = LETTER_W'(v);
            k++;
         end
      end
      if (kind == SQ_SHUFFLE) begin
         for (int s = SQUARE_SIDE * SQUARE_SIDE - 1; s > 0; s--) begin
            pick = $urandom_range(s);
            swap = cells[s];
            cells[s] = cells[pick];
            cells[pick] = swap;
         end
      end
      for (int r = 0; r < SQUARE_SIDE; r++) begin
         word = '0;
         for (int c = 0; c < SQUARE_SIDE; c++) begin
            word[LETTER_W*c +: LETTER_W] = cells[r*SQUARE_SIDE + c];
         end
         case (kind)
            SQ_ZERO: word = '0;
            SQ_ONES: word = 32'h01FF_FFFF;
            SQ_NOISE: word = $urandom();
            default: ;
         endcase
         set_register(IDX_W'(REG_ROW0 + r), word);
      end
      set_register(REG_MODE, {31'd0, mode});
   endtask

   task automatic push_item(input logic [7:0] ch, input logic fin);
      text_queue.push_back('{text_byte: ch, text_last: fin});
   endtask

   task automatic push_text(input string s, input logic fin);
      for (int k = 0; k < s.len(); k++) begin
         push_item(s[k], fin && (k == s.len() - 1));
      end
   endtask

   // Mostly letters of either case with frequent doubles; the rest is noise.
   task automatic push_random(input int count);
      int         pick;
      logic [7:0] ch;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            ch = prev_byte;
         end else if (pick < 50) begin
            ch = CHAR_LOWER_A + 8'($urandom_range(LETTER_MAX));
         end else if (pick < 82) begin
            ch = CHAR_UPPER_A + 8'($urandom_range(LETTER_MAX));
         end else begin
            ch = 8'($urandom_range(255));
         end
         prev_byte = ch;
         push_item(ch, $urandom_range(11) == 0);
      end
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (text_queue.size() != 0 || req_tvalid || letter_expect.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int kind;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         case (p)
            0, 1: kind = SQ_ALPHA;
            2: kind = SQ_ONES;
            3: kind = SQ_ZERO;
            6, 7: kind = SQ_NOISE;
            default: kind = SQ_SHUFFLE;
         endcase
         load_config(p % 2, kind);
         @(negedge clock);
         if (p == 0) begin
            // Row, column and rectangle pairs, both wraps, bytes at the letter
            // range edges, j folding, doubled x, a four-letter burst, and a
            // last flag with nothing held.
            push_text("Ab@af[AG`ea{va", 1'b0);
            push_text("JjxXx", 1'b0);
            push_text("e", 1'b1);
            push_text("qq", 1'b1);
            push_item(8'hFF, 1'b1);
            push_text("k", 1'b0);
            push_item(8'h00, 1'b1);
         end else if (p == 1) begin
            // Decrypt keeps doubled letters and still pads a lone last letter.
            push_text("bcgfzz", 1'b0);
            push_text("m", 1'b1);
            push_item(8'h80, 1'b0);
            push_item(8'h7F, 1'b1);
         end else if (p == 4) begin
            hold_requests++;
            push_random(PHASE_ITEMS);
         end else if (p == 6) begin
            push_random(PHASE_ITEMS / 2);
            wait_drained();
            push_random(PHASE_ITEMS / 2);
         end else begin
            push_random(PHASE_ITEMS);
         end
         wait_drained();
      end
      $display("Run covered %0d text bytes over %0d square and mode settings.",
               items_accepted, PHASES);
      $display("Checked %0d letters, %0d text ends and %0d four-letter bursts.",
               letters_checked, texts_closed, bursts_seen);
      if (error_count == 0) begin
         $display("playfair_text_cipher_core regression: pass");
      end else begin
         $display("playfair_text_cipher_core regression: fail");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/pfc_pkg.sv
rtl/pfc_csr.sv
rtl/pfc_front.sv
rtl/pfc_queue.sv
rtl/pfc_back.sv
rtl/playfair_text_cipher_core.sv
tb/tb_top.sv
